[rtl/core/htfd_pkg.sv]
package htfd_pkg;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  localparam logic [14:0] TempScale   = 15'd17500;
  localparam logic [14:0] TempOffset  = 15'd4500;
  localparam logic [13:0] HumScale    = 14'd10000;
  localparam logic [30:0] RoundHalf   = 31'd32767;
  localparam logic [16:0] DivConst    = 17'd65535;

  // byte positions within a frame
  localparam logic [2:0] PosTempMsb = 3'd0;
  localparam logic [2:0] PosTempLsb = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumMsb  = 3'd3;
  localparam logic [2:0] PosHumLsb  = 3'd4;
  localparam logic [2:0] PosHumCrc  = 3'd5;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(y / 65535) for y below 2^31, by shift and one correction
  function automatic logic [14:0] div_65535(input logic [30:0] y);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = y[30:16];
    r  = {1'b0, y[15:0]} + 17'(q0);
    return q0 + 15'(r >= DivConst);
  endfunction

endpackage

[rtl/core/humidity_temp_frame_decoder.sv]
// Measurement frame decoder.
// Input channel: one frame byte per word on rx_byte_i, with frame_start_i
// marking byte zero of a frame; in_valid_i / in_stall_o handshake.
// A frame is temperature MSB, LSB, CRC, humidity MSB, LSB, CRC; each
// two-byte word is checked with CRC-8 (poly 0x31, init 0xFF, MSB first).
// Output channel: one word per frame after the sixth byte, carrying
// status_o (0 both CRCs good, 1 mismatch), temp_centi_o and
// humidity_centi_o (hundredths, rounded; both zero on mismatch);
// out_valid_o / out_stall_i handshake.
// A byte is held in the input register and is then decoded into the
// result register, so out_valid_o rises once the sixth byte has passed
// from the input register into the result register.
// Throughput: one byte per cycle; the input and frame state registers keep
// accepting while a result waits, only a sixth byte waits behind a
// stalled, full result register.
// Reset: byte position returns to zero and the CRC to 0xFF; no result is
// pending. A stalled result holds its value until taken.
module humidity_temp_frame_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 frame_start_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 status_o,
  output logic signed [14:0]   temp_centi_o,
  output logic [13:0]          humidity_centi_o
);
  import htfd_pkg::*;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        start_q;

  logic [2:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_word_q, temp_word_d;
  logic [7:0]  hum_high_q, hum_high_d;
  logic [7:0]  hum_low_q, hum_low_d;
  logic        temp_good_q, temp_good_d;
  logic [14:0] temp_raw_q, temp_raw_d;

  logic        out_valid_q;
  logic        status_q, status_d;
  logic [14:0] temp_out_q, temp_out_d;
  logic [13:0] hum_out_q, hum_out_d;

  logic [2:0]  pos;
  logic        emit;
  logic        out_free;
  logic        advance;
  logic        take_in;
  logic [30:0] temp_prod;
  logic [30:0] hum_prod;
  logic [13:0] hum_scaled;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    pos = pos_q;
    if (start_q || pos_q > PosHumCrc) begin
      pos = PosTempMsb;
    end
  end

  assign emit       = in_valid_q && (pos == PosHumCrc);
  assign advance    = in_valid_q && (!emit || out_free);
  assign take_in    = !in_valid_q || advance;
  assign in_stall_o = !take_in;

  assign temp_prod  = 31'(temp_word_q) * 31'(TempScale);
  assign hum_prod   = 31'({hum_high_q, hum_low_q}) * 31'(HumScale);
  assign hum_scaled = 14'(div_65535(hum_prod + RoundHalf));

  always_comb begin
    pos_d       = pos + 3'd1;
    crc_d       = crc_q;
    temp_word_d = temp_word_q;
    hum_high_d  = hum_high_q;
    hum_low_d   = hum_low_q;
    temp_good_d = temp_good_q;
    temp_raw_d  = temp_raw_q;
    status_d    = STATUS_FAIL;
    temp_out_d  = '0;
    hum_out_d   = '0;
    unique case (pos)
      PosTempMsb: begin
        crc_d       = crc8_byte(CrcInit, byte_q);
        temp_word_d = {byte_q, 8'h00};
      end
      PosTempLsb: begin
        crc_d       = crc8_byte(crc_q, byte_q);
        temp_word_d = {temp_word_q[15:8], byte_q};
      end
      PosTempCrc: begin
        temp_good_d = (crc_q == byte_q);
        crc_d       = CrcInit;
        temp_raw_d  = div_65535(temp_prod + RoundHalf);
      end
      PosHumMsb: begin
        crc_d      = crc8_byte(CrcInit, byte_q);
        hum_high_d = byte_q;
      end
      PosHumLsb: begin
        crc_d     = crc8_byte(crc_q, byte_q);
        hum_low_d = byte_q;
      end
      default: begin
        crc_d = CrcInit;
        pos_d = PosTempMsb;
        if (temp_good_q && (crc_q == byte_q)) begin
          status_d   = STATUS_OK;
          temp_out_d = temp_raw_q - TempOffset;
          hum_out_d  = hum_scaled;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in && in_valid_i) begin
      byte_q  <= rx_byte_i;
      start_q <= frame_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosTempMsb;
      crc_q       <= CrcInit;
      temp_word_q <= '0;
      hum_high_q  <= '0;
      hum_low_q   <= '0;
      temp_good_q <= 1'b0;
      temp_raw_q  <= '0;
    end else if (advance) begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      temp_word_q <= temp_word_d;
      hum_high_q  <= hum_high_d;
      hum_low_q   <= hum_low_d;
      temp_good_q <= temp_good_d;
      temp_raw_q  <= temp_raw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      status_q   <= status_d;
      temp_out_q <= temp_out_d;
      hum_out_q  <= hum_out_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign temp_centi_o     = $signed(temp_out_q);
  assign humidity_centi_o = hum_out_q;

endmodule
